// ===== rtl/core/crc32_word_engine_assert.svh =====
// Assertion macros for the CRC-32 word engine RTL.
`ifndef CRC32_WORD_ENGINE_ASSERT_SVH
`define CRC32_WORD_ENGINE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CWE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cwe: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CWE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cwe: next-cycle check failed");

`endif

// ===== rtl/core/cwe_pkg.sv =====
// Shared constants, types and the CRC advance function for the CRC-32 word engine.
`timescale 1ns / 1ps
`default_nettype none
package cwe_pkg;

   localparam int CRC_W     = 32;
   localparam int DATA_W    = 64;
   localparam int COUNT_W   = 4;
   localparam int BYTE_BITS = 8;
   localparam int MAX_BYTES = 8;

   localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [CRC_W-1:0] CRC_INVERT = 32'hFFFFFFFF;

   // Control that moves from the stage register into the remainder fold
   typedef struct packed {
      logic               advance;
      logic               first;
      logic [COUNT_W-1:0] nbytes;
   } cwe_ctl_type;

   // Step a reflected remainder through nbits zero bits (elaboration use only)
   function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] r,
                                                    input int nbits);
      logic [CRC_W-1:0] acc;
      acc = r;
      for (int i = 0; i < nbits; i++) begin
         acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : '0);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cwe_lane.sv =====
// One byte lane: picks its right-aligned byte and maps it through a fixed CRC matrix.
`timescale 1ns / 1ps
`default_nettype none
module cwe_lane #(
   parameter int BYTES_PER_WORD = 8,
   parameter int LANE           = 0
) (
   input  wire logic [cwe_pkg::DATA_W-1:0]  data_word,
   input  wire logic [cwe_pkg::COUNT_W-1:0] nbytes,
   output logic      [cwe_pkg::CRC_W-1:0]   contrib
);
   import cwe_pkg::*;

   // Lane LANE holds the byte that still has this many bytes to pass
   localparam int SHIFT_BITS = BYTE_BITS * (BYTES_PER_WORD - LANE);

   logic [COUNT_W-1:0]   pos;
   logic                 hit;
   logic [2:0]           src;
   logic [BYTE_BITS-1:0] lane_byte;
   logic [CRC_W-1:0]     col [BYTE_BITS];

   // Right-align the valid bytes: lanes below the gap see zero
   assign pos       = COUNT_W'(LANE) + nbytes;
   assign hit       = (pos >= COUNT_W'(BYTES_PER_WORD));
   assign src       = 3'(pos - COUNT_W'(BYTES_PER_WORD));
   assign lane_byte = hit ? data_word[{src, 3'b000} +: BYTE_BITS] : '0;

   // Matrix columns, one per input bit
   for (genvar k = 0; k < BYTE_BITS; k++) begin : g_col
      localparam logic [CRC_W-1:0] COL = crc_advance(CRC_W'(1) << k, SHIFT_BITS);
      assign col[k] = COL;
   end

   // Multiply the byte by the matrix over GF(2)
   always_comb begin
      contrib = '0;
      for (int k = 0; k < BYTE_BITS; k++) begin
         contrib = contrib ^ (lane_byte[k] ? col[k] : '0);
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/cwe_fold.sv =====
// Running remainder: advances the old remainder by the word's byte count and adds the data part.
`timescale 1ns / 1ps
`default_nettype none
module cwe_fold #(
   parameter int BYTES_PER_WORD = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cwe_pkg::cwe_ctl_type      ctl,
   input  wire logic [cwe_pkg::CRC_W-1:0] seed_crc,
   input  wire logic [cwe_pkg::CRC_W-1:0] data_part,
   output logic      [cwe_pkg::CRC_W-1:0] crc_next
);
   import cwe_pkg::*;

   localparam int SEL_W = $clog2(BYTES_PER_WORD + 1);

   logic [CRC_W-1:0] remainder_ff;
   logic [CRC_W-1:0] remainder_in;
   logic [CRC_W-1:0] base;
   logic [CRC_W-1:0] mat     [BYTES_PER_WORD+1][CRC_W];
   logic [CRC_W-1:0] shifted [BYTES_PER_WORD+1];
   logic [SEL_W-1:0] sel;

   // Load the inverted seed on a first word, else continue
   assign base = ctl.first ? (seed_crc ^ CRC_INVERT) : remainder_ff;

   // Zero-byte advance matrices for every possible byte count
   for (genvar n = 0; n <= BYTES_PER_WORD; n++) begin : g_cnt
      for (genvar k = 0; k < CRC_W; k++) begin : g_col
         localparam logic [CRC_W-1:0] COL = crc_advance(CRC_W'(1) << k, BYTE_BITS * n);
         assign mat[n][k] = COL;
      end

      always_comb begin
         shifted[n] = '0;
         for (int k = 0; k < CRC_W; k++) begin
            shifted[n] = shifted[n] ^ (base[k] ? mat[n][k] : '0);
         end
      end
   end

   // Pick the advance for this word and add the lanes' data part
   assign sel          = ctl.nbytes[SEL_W-1:0];
   assign remainder_in = shifted[sel] ^ data_part;
   assign crc_next     = remainder_in ^ CRC_INVERT;

   // Hold the remainder between words
   always_ff @(posedge clock) begin
      if (reset) begin
         remainder_ff <= '0;
      end else if (ctl.advance) begin
         remainder_ff <= remainder_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/crc32_word_engine.sv =====
// CRC-32 (reflected 0xEDB88320) word engine: byte lanes, merge stage, remainder fold.
//
// Usage:
//   The req_ channel carries one 64-bit word per transfer with 0 to 8 valid
//   low-order bytes (req_byte_count; counts above BYTES_PER_WORD saturate).
//   req_first_word loads req_seed_crc as the starting CRC; req_last_word
//   closes the message and yields one rsp_ transfer with the final CRC.
//   Words without req_last_word yield nothing. An empty one-word message
//   returns the seed unchanged.
//   The result passes through the stage register and then the output
//   register before it is valid on rsp_.
//   Throughput: one word per cycle unless a last word stalls; the remainder
//   update is a combinational matrix multiply selected by byte count.
//   Reset clears the pipeline valids and the remainder to zero; a message
//   that starts without a first word continues from that remainder.
//   When rsp_ready is low, the output register holds its CRC; words that
//   are not last keep flowing, and a last word waits in the stage register,
//   which drops req_ready until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "crc32_word_engine_assert.svh"
module crc32_word_engine #(
   parameter int BYTES_PER_WORD = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_first_word,
   input  wire logic [cwe_pkg::CRC_W-1:0]   req_seed_crc,
   input  wire logic [cwe_pkg::DATA_W-1:0]  req_data_word,
   input  wire logic [cwe_pkg::COUNT_W-1:0] req_byte_count,
   input  wire logic                        req_last_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [cwe_pkg::CRC_W-1:0]   rsp_crc_value
);
   import cwe_pkg::*;

   logic [COUNT_W-1:0] nbytes;
   logic [CRC_W-1:0]   lane_contrib [BYTES_PER_WORD];
   logic [CRC_W-1:0]   data_merge;
   logic               accept;
   logic               s1_go;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic               s1_first_ff;
   logic               s1_last_ff;
   logic [COUNT_W-1:0] s1_nbytes_ff;
   logic [CRC_W-1:0]   s1_seed_ff;
   logic [CRC_W-1:0]   s1_data_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [CRC_W-1:0]   rsp_crc_ff;
   logic [CRC_W-1:0]   crc_next;
   cwe_ctl_type        fold_ctl;

   // Saturate the byte count to the lane count
   assign nbytes = (req_byte_count > COUNT_W'(BYTES_PER_WORD)) ?
                   COUNT_W'(BYTES_PER_WORD) : req_byte_count;

   // Byte lanes
   for (genvar j = 0; j < BYTES_PER_WORD; j++) begin : g_lane
      cwe_lane #(
         .BYTES_PER_WORD (BYTES_PER_WORD),
         .LANE           (j)
      ) u_lane (
         .data_word (req_data_word),
         .nbytes    (nbytes),
         .contrib   (lane_contrib[j])
      );
   end

   // Merge the lane contributions
   always_comb begin
      data_merge = '0;
      for (int j = 0; j < BYTES_PER_WORD; j++) begin
         data_merge = data_merge ^ lane_contrib[j];
      end
   end

   // Stage handshake: a last word moves on only into a free output register
   assign s1_go     = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the merged word on each input transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_first_ff  <= req_first_word;
         s1_last_ff   <= req_last_word;
         s1_nbytes_ff <= nbytes;
         s1_seed_ff   <= req_seed_crc;
         s1_data_ff   <= data_merge;
      end
   end

   // Fold the word into the running remainder
   assign fold_ctl = '{advance: s1_go, first: s1_first_ff, nbytes: s1_nbytes_ff};

   cwe_fold #(
      .BYTES_PER_WORD (BYTES_PER_WORD)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fold_ctl),
      .seed_crc  (s1_seed_ff),
      .data_part (s1_data_ff),
      .crc_next  (crc_next)
   );

   // Output register: fill on a last word, drop on a result transfer
   always_comb begin
      priority if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         rsp_crc_ff <= crc_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   // Checks
   `CWE_ASSERT_NEXT(a_accept_fills_stage, req_valid && req_ready, s1_valid_ff)
   `CWE_ASSERT_NEXT(a_stall_holds_stage, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_data_ff))
   `CWE_ASSERT_NEXT(a_stall_holds_count, s1_valid_ff && !s1_go, $stable(s1_nbytes_ff))
   `CWE_ASSERT_NEXT(a_last_yields_rsp, s1_go && s1_last_ff, rsp_valid)
   `CWE_ASSERT_SAME(a_no_rsp_overwrite, rsp_valid && !rsp_ready, !(s1_go && s1_last_ff))

endmodule
`default_nettype wire
